// ===== src/biou_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package biou_pkg;

	// Coordinate and result formats.
	localparam int CoordBits = 16;
	localparam int FracBits  = 16;
	localparam int RatioBits = FracBits + 1;
	localparam logic [RatioBits-1:0] OneQ16 = RatioBits'(1) << FracBits;

	// Derived datapath widths.
	localparam int DiffBits  = CoordBits + 1;
	localparam int SideBits  = CoordBits;
	localparam int InterBits = 2 * SideBits;
	localparam int AreaBits  = 2 * DiffBits;
	localparam int UnionBits = AreaBits + 2;
	localparam int RemBits   = AreaBits;

	// Input word: one test box and one reference box.
	typedef struct packed {
		logic signed [CoordBits-1:0] test_x1;
		logic signed [CoordBits-1:0] test_y1;
		logic signed [CoordBits-1:0] test_x2;
		logic signed [CoordBits-1:0] test_y2;
		logic signed [CoordBits-1:0] ref_x1;
		logic signed [CoordBits-1:0] ref_y1;
		logic signed [CoordBits-1:0] ref_x2;
		logic signed [CoordBits-1:0] ref_y2;
	} biou_in_t;

	// Output word.
	typedef struct packed {
		logic [RatioBits-1:0] overlap_ratio;
		logic                 empty_union;
	} biou_out_t;

	// State carried through the divider stages.
	typedef struct packed {
		logic [RemBits-1:0]  rem;
		logic [RemBits-1:0]  dvs;
		logic [FracBits-1:0] quo;
		logic                empty;
		logic                sat;
	} biou_div_t;

endpackage

`default_nettype wire

// ===== src/biou_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module biou_geom
	import biou_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      valid_in,
	input  wire biou_in_t  box,
	input  wire logic [2:0] en,
	output logic [2:0]     valid,
	output biou_div_t      div_out
);

	// Stage 1: overlap extents and box sides.
	logic signed [CoordBits-1:0] ix1, ix2, iy1, iy2;
	logic signed [DiffBits-1:0]  w_raw, h_raw;
	logic [SideBits-1:0]         w_s1, h_s1;
	logic signed [DiffBits-1:0]  tdx_s1, tdy_s1, rdx_s1, rdy_s1;

	always_comb begin
		ix1 = (box.test_x1 > box.ref_x1) ? box.test_x1 : box.ref_x1;
		iy1 = (box.test_y1 > box.ref_y1) ? box.test_y1 : box.ref_y1;
		ix2 = (box.test_x2 < box.ref_x2) ? box.test_x2 : box.ref_x2;
		iy2 = (box.test_y2 < box.ref_y2) ? box.test_y2 : box.ref_y2;
		w_raw = DiffBits'(ix2) - DiffBits'(ix1);
		h_raw = DiffBits'(iy2) - DiffBits'(iy1);
	end

	always_ff @(posedge clk) begin
		if (en[0] && valid_in) begin
			w_s1   <= w_raw[DiffBits-1] ? '0 : w_raw[SideBits-1:0];
			h_s1   <= h_raw[DiffBits-1] ? '0 : h_raw[SideBits-1:0];
			tdx_s1 <= DiffBits'(box.test_x2) - DiffBits'(box.test_x1);
			tdy_s1 <= DiffBits'(box.test_y2) - DiffBits'(box.test_y1);
			rdx_s1 <= DiffBits'(box.ref_x2) - DiffBits'(box.ref_x1);
			rdy_s1 <= DiffBits'(box.ref_y2) - DiffBits'(box.ref_y1);
		end
	end

	// Stage 2: intersection area and the two signed box areas.
	logic [InterBits-1:0]       inter_s2;
	logic signed [AreaBits-1:0] at_s2, ar_s2;

	always_ff @(posedge clk) begin
		if (en[1] && valid[0]) begin
			inter_s2 <= InterBits'(w_s1) * InterBits'(h_s1);
			at_s2    <= AreaBits'(tdx_s1) * AreaBits'(tdy_s1);
			ar_s2    <= AreaBits'(rdx_s1) * AreaBits'(rdy_s1);
		end
	end

	// Stage 3: union, empty and saturation flags, divider setup.
	logic signed [UnionBits-1:0] uni;
	logic [UnionBits-1:0]        inter_ext;
	biou_div_t                   div_s3;

	always_comb begin
		inter_ext = UnionBits'(inter_s2);
		uni = UnionBits'(at_s2) + UnionBits'(ar_s2) - $signed(inter_ext);
	end

	always_ff @(posedge clk) begin
		if (en[2] && valid[1]) begin
			div_s3.rem   <= RemBits'(inter_s2);
			div_s3.dvs   <= uni[RemBits-1:0];
			div_s3.quo   <= '0;
			div_s3.empty <= uni[UnionBits-1] || (uni == '0);
			div_s3.sat   <= inter_ext >= $unsigned(uni);
		end
	end

	assign div_out = div_s3;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= '0;
		end else begin
			if (en[0]) valid[0] <= valid_in;
			if (en[1]) valid[1] <= valid[0];
			if (en[2]) valid[2] <= valid[1];
		end
	end

endmodule

`default_nettype wire

// ===== src/biou_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module biou_div_step
	import biou_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      valid_in,
	input  wire biou_div_t div_in,
	output logic           valid,
	output biou_div_t      div_out
);

	// One restoring division step: one quotient bit per stage.
	logic [RemBits:0] shifted;
	logic [RemBits:0] dvs_ext;
	logic [RemBits:0] diff;
	logic             take;
	biou_div_t        nxt;

	always_comb begin
		shifted   = {div_in.rem, 1'b0};
		dvs_ext   = {1'b0, div_in.dvs};
		diff      = shifted - dvs_ext;
		take      = shifted >= dvs_ext;
		nxt       = div_in;
		nxt.rem   = take ? diff[RemBits-1:0] : shifted[RemBits-1:0];
		nxt.quo   = {div_in.quo[FracBits-2:0], take};
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			div_out <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= valid_in;
		end
	end

endmodule

`default_nettype wire

// ===== src/box_iou_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Box intersection-over-union unit.
// The pair channel (pair, pair_valid, pair_stall) takes one test box and one
// reference box per word, as signed corner coordinates. The iou channel
// (iou, iou_valid, iou_stall) returns one word per pair, in order: the ratio
// in unsigned Q1.16 (65536 is one), truncated, and a flag for a union that
// is not positive, in which case the ratio is zero.
// A word is moved at a rising edge where valid is high and stall is low.
// Throughput is one pair per cycle while iou_stall is low. A pair passes
// three geometry stages (extents, multiplies, union), sixteen restoring
// divider stages at one quotient bit each, and the output register.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up while the receiver stalls; pair_stall rises only once
// every stage holds a word and iou_stall is high. No word is dropped or
// repeated. Reset clears all valid bits; the data registers are not reset.
module box_iou_unit
	import biou_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire biou_in_t  pair,
	input  wire logic      pair_valid,
	output logic           pair_stall,
	output biou_out_t      iou,
	output logic           iou_valid,
	input  wire logic      iou_stall
);

	logic [2:0]          geom_en;
	logic [2:0]          geom_valid;
	logic [FracBits-1:0] div_en;
	logic [FracBits-1:0] div_valid;
	biou_div_t           div_chain [FracBits+1];
	logic                out_en;

	// Stage enables: a stage moves when it is empty or its successor moves.
	assign out_en = !iou_valid || !iou_stall;
	assign div_en[FracBits-1] = !div_valid[FracBits-1] || out_en;

	genvar k;
	generate
		for (k = 0; k < FracBits - 1; k++) begin : g_div_en
			assign div_en[k] = !div_valid[k] || div_en[k+1];
		end
	endgenerate

	assign geom_en[2] = !geom_valid[2] || div_en[0];
	assign geom_en[1] = !geom_valid[1] || geom_en[2];
	assign geom_en[0] = !geom_valid[0] || geom_en[1];
	assign pair_stall = !geom_en[0];

	// Geometry front end.
	biou_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (pair_valid),
		.box      (pair),
		.en       (geom_en),
		.valid    (geom_valid),
		.div_out  (div_chain[0])
	);

	// Divider pipeline.
	generate
		for (k = 0; k < FracBits; k++) begin : g_div
			biou_div_step u_step (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (div_en[k]),
				.valid_in ((k == 0) ? geom_valid[2] : div_valid[(k == 0) ? 0 : k-1]),
				.div_in   (div_chain[k]),
				.valid    (div_valid[k]),
				.div_out  (div_chain[k+1])
			);
		end
	endgenerate

	// Output register: select the ratio from the flags and the quotient.
	biou_div_t last;
	biou_out_t res;

	always_comb begin
		last = div_chain[FracBits];
		res.empty_union = last.empty;
		if (last.empty) begin
			res.overlap_ratio = '0;
		end else if (last.sat) begin
			res.overlap_ratio = OneQ16;
		end else begin
			res.overlap_ratio = RatioBits'(last.quo);
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && div_valid[FracBits-1]) begin
			iou <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_valid <= 1'b0;
		end else if (out_en) begin
			iou_valid <= div_valid[FracBits-1];
		end
	end

`ifndef SYNTHESIS
	// An empty union always comes out with a zero ratio.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		iou_valid && iou.empty_union |-> iou.overlap_ratio == '0)
		else $error("empty union with nonzero ratio");

	// The ratio never exceeds one.
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		iou_valid |-> iou.overlap_ratio <= OneQ16)
		else $error("ratio above one");

	// Back-pressure only appears when the receiver holds a word back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> iou_valid && iou_stall)
		else $error("input stalled without output stall");

	// A valid output word under stall stays valid and unchanged.
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		iou_valid && iou_stall |=> iou_valid && $stable(iou))
		else $error("output word changed under stall");
`endif

endmodule

`default_nettype wire
